// File: hdl/tdq_pkg.sv
package tdq_pkg;

   // coordinate width and the derived word type
   localparam int COORD_BITS = 24;
   typedef logic [COORD_BITS-1:0] coord_type;

   // normalisation bound and the rounding layout of a normalised magnitude
   localparam coord_type NORM_LIMIT = coord_type'(12'h700);
   localparam int        ROUND_BIT  = 7;
   localparam int        STEP_LSB   = 8;
   localparam int        STEP_BITS  = 3;
   localparam int        DIR_BITS   = 5;

   typedef logic [STEP_BITS-1:0] step_type;
   typedef logic [DIR_BITS-1:0]  dir_type;

   // offset applied when the horizontal axis is negative
   localparam dir_type DIR_X_OFFSET = dir_type'(5'h10);

   // shared arithmetic unit operations
   typedef enum logic [0:0] {
      ALU_SUB,
      ALU_NEG
   } alu_op_type;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SUB_X,
      ST_SUB_Y,
      ST_NEG_X,
      ST_NEG_Y,
      ST_SHIFT,
      ST_LOOKUP
   } state_type;

   // packed heading table: two nibbles per byte, high nibble for even index
   typedef logic [7:0] nibble_pair_type;
   localparam nibble_pair_type HEADING_NIBBLES [32] = '{
      8'h40, 8'h00, 8'h00, 8'h00, 8'h84, 8'h22, 8'h11, 8'h11,
      8'h86, 8'h43, 8'h22, 8'h21, 8'h86, 8'h54, 8'h33, 8'h22,
      8'h87, 8'h65, 8'h43, 8'h33, 8'h87, 8'h65, 8'h54, 8'h43,
      8'h87, 8'h66, 8'h54, 8'h44, 8'h87, 8'h76, 8'h55, 8'h44
   };

endpackage

// File: hdl/tdq_alu.sv
module tdq_alu (
   input  tdq_pkg::alu_op_type op,
   input  tdq_pkg::coord_type  operand_a,
   input  tdq_pkg::coord_type  operand_b,
   output tdq_pkg::coord_type  result
);
   import tdq_pkg::*;

   // one subtractor, modulo 2^COORD_BITS; negate is zero minus operand A
   coord_type minuend;
   coord_type subtrahend;

   always_comb begin
      unique case (op)
         ALU_SUB: begin
            minuend    = operand_a;
            subtrahend = operand_b;
         end
         ALU_NEG: begin
            minuend    = '0;
            subtrahend = operand_a;
         end
         default: begin
            minuend    = operand_a;
            subtrahend = operand_b;
         end
      endcase
   end

   assign result = minuend - subtrahend;

endmodule

// File: hdl/tdq_heading.sv
module tdq_heading (
   input  tdq_pkg::coord_type mag_x,
   input  tdq_pkg::coord_type mag_y,
   input  logic               x_neg,
   input  logic               y_neg,
   output tdq_pkg::dir_type   direction
);
   import tdq_pkg::*;

   step_type        step_x;
   step_type        step_y;
   logic [5:0]      index;
   nibble_pair_type pair;
   dir_type         nibble;
   dir_type         after_y;

   // round each normalised magnitude to a 0..7 step by bit 7
   assign step_x = mag_x[STEP_LSB +: STEP_BITS] + step_type'(mag_x[ROUND_BIT]);
   assign step_y = mag_y[STEP_LSB +: STEP_BITS] + step_type'(mag_y[ROUND_BIT]);

   // table fetch, high nibble for an even index
   assign index  = {step_y, step_x};
   assign pair   = HEADING_NIBBLES[index[5:1]];
   assign nibble = index[0] ? dir_type'(pair[3:0]) : dir_type'(pair[7:4]);

   // quadrant fix-up, kept to five bits
   assign after_y   = y_neg ? dir_type'(-nibble) : nibble;
   assign direction = x_neg ? dir_type'(DIR_X_OFFSET - after_y) : after_y;

endmodule

// File: hdl/target_direction_quantizer.sv
// Heading quantiser: takes a target point and an own point and returns one of
// 32 directions toward the target. A request is taken when start is high and
// busy is low; one result beat follows on rsp_valid for a single cycle and
// cannot be held off, so the receiver must take it when it appears. The block
// first runs the shared subtractor for two differences and two conditional
// negations, then makes n right shifts, where n (0 to COORD_BITS - 11, so at
// most 13) is the number the shared datapath needs to bring both magnitudes
// below 0x700, and then does the table lookup. A new request may be started in
// the cycle the result is shown.
module target_direction_quantizer (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [tdq_pkg::COORD_BITS-1:0]   req_target_x,
   input  logic [tdq_pkg::COORD_BITS-1:0]   req_target_y,
   input  logic [tdq_pkg::COORD_BITS-1:0]   req_own_x,
   input  logic [tdq_pkg::COORD_BITS-1:0]   req_own_y,
   output logic                             rsp_valid,
   output logic [tdq_pkg::DIR_BITS-1:0]     rsp_direction
);
   import tdq_pkg::*;

   state_type  state_ff, state_in;
   coord_type  mag_x_ff, mag_x_in;
   coord_type  mag_y_ff, mag_y_in;
   coord_type  own_x_ff, own_x_in;
   coord_type  own_y_ff, own_y_in;
   logic       x_neg_ff, x_neg_in;
   logic       y_neg_ff, y_neg_in;
   logic       valid_ff, valid_in;
   dir_type    dir_ff, dir_in;

   alu_op_type alu_op;
   coord_type  alu_a;
   coord_type  alu_b;
   coord_type  alu_result;
   dir_type    heading;
   logic       too_big;

   tdq_alu u_alu (
      .op        (alu_op),
      .operand_a (alu_a),
      .operand_b (alu_b),
      .result    (alu_result)
   );

   tdq_heading u_heading (
      .mag_x     (mag_x_ff),
      .mag_y     (mag_y_ff),
      .x_neg     (x_neg_ff),
      .y_neg     (y_neg_ff),
      .direction (heading)
   );

   assign too_big = (mag_x_ff >= NORM_LIMIT) || (mag_y_ff >= NORM_LIMIT);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      mag_x_ff <= mag_x_in;
      mag_y_ff <= mag_y_in;
      own_x_ff <= own_x_in;
      own_y_ff <= own_y_in;
      x_neg_ff <= x_neg_in;
      y_neg_ff <= y_neg_in;
      dir_ff   <= dir_in;
   end

   // sequencer: next state, shared unit operands, datapath updates
   always_comb begin
      state_in = state_ff;
      mag_x_in = mag_x_ff;
      mag_y_in = mag_y_ff;
      own_x_in = own_x_ff;
      own_y_in = own_y_ff;
      x_neg_in = x_neg_ff;
      y_neg_in = y_neg_ff;
      valid_in = 1'b0;
      dir_in   = dir_ff;
      alu_op   = ALU_SUB;
      alu_a    = mag_x_ff;
      alu_b    = own_x_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               mag_x_in = req_target_x;
               mag_y_in = req_target_y;
               own_x_in = req_own_x;
               own_y_in = req_own_y;
               state_in = ST_SUB_X;
            end
         end
         ST_SUB_X: begin
            mag_x_in = alu_result;
            x_neg_in = alu_result[COORD_BITS-1];
            state_in = ST_SUB_Y;
         end
         ST_SUB_Y: begin
            alu_a    = mag_y_ff;
            alu_b    = own_y_ff;
            mag_y_in = alu_result;
            y_neg_in = alu_result[COORD_BITS-1];
            state_in = ST_NEG_X;
         end
         ST_NEG_X: begin
            alu_op = ALU_NEG;
            if (x_neg_ff) begin
               mag_x_in = alu_result;
            end
            state_in = ST_NEG_Y;
         end
         ST_NEG_Y: begin
            alu_op = ALU_NEG;
            alu_a  = mag_y_ff;
            if (y_neg_ff) begin
               mag_y_in = alu_result;
            end
            state_in = ST_SHIFT;
         end
         ST_SHIFT: begin
            // shift both together, one place a cycle
            if (too_big) begin
               mag_x_in = mag_x_ff >> 1;
               mag_y_in = mag_y_ff >> 1;
            end else begin
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            dir_in   = heading;
            valid_in = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy          = (state_ff != ST_IDLE);
   assign rsp_valid     = valid_ff;
   assign rsp_direction = dir_ff;

endmodule

// File: bench/target_direction_quantizer_tb.sv
`timescale 1ns / 100ps

module target_direction_quantizer_tb;

   import tdq_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 24;

   logic      clock;
   logic      reset;
   logic      start;
   logic      busy;
   coord_type req_target_x;
   coord_type req_target_y;
   coord_type req_own_x;
   coord_type req_own_y;
   logic      rsp_valid;
   dir_type   rsp_direction;

   dir_type     heading_due[$];
   int unsigned mismatch_count;
   int unsigned quiet_cycles;
   bit          gaps_on;

   target_direction_quantizer dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_target_x  (req_target_x),
      .req_target_y  (req_target_y),
      .req_own_x     (req_own_x),
      .req_own_y     (req_own_y),
      .rsp_valid     (rsp_valid),
      .rsp_direction (rsp_direction)
   );

   // 4 ns clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // expected heading: wrap the differences, fold to magnitudes, normalise,
   // round each axis to a step, look up the nibble and fold the quadrant back
   function automatic dir_type predict_heading(coord_type tx, coord_type ty,
                                               coord_type ox, coord_type oy);
      coord_type  dx, dy, mx, my;
      logic       x_neg, y_neg;
      int         sx, sy;
      logic [5:0] idx;
      logic [7:0] pair;
      logic [7:0] a;
      dx    = tx - ox;
      dy    = ty - oy;
      x_neg = dx[COORD_BITS-1];
      y_neg = dy[COORD_BITS-1];
      mx    = x_neg ? coord_type'(-dx) : dx;
      my    = y_neg ? coord_type'(-dy) : dy;
      while (mx >= NORM_LIMIT || my >= NORM_LIMIT) begin
         mx = mx >> 1;
         my = my >> 1;
      end
      sx   = int'(mx[15:8]) + int'(mx[ROUND_BIT]);
      sy   = int'(my[15:8]) + int'(my[ROUND_BIT]);
      idx  = 6'(sy * 8 + sx);
      pair = HEADING_NIBBLES[idx[5:1]];
      a    = idx[0] ? {4'h0, pair[3:0]} : {4'h0, pair[7:4]};
      if (y_neg)
         a = 8'h00 - a;
      if (x_neg)
         a = 8'(8'h00 - a) + 8'h10;
      return a[DIR_BITS-1:0];
   endfunction

   task automatic report_mismatch(string what, int exp_val, int got_val);
      mismatch_count++;
      $display("%0t ns: %s: expected %0d, got %0d", $time, what, exp_val, got_val);
   endtask

   // one request beat; called at a rising edge, returns at the accepting edge
   task automatic send_query(coord_type tx, coord_type ty, coord_type ox, coord_type oy);
      if (gaps_on && $urandom_range(99) < 28) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 22)) @(posedge clock);
      end
      start        <= 1'b1;
      req_target_x <= tx;
      req_target_y <= ty;
      req_own_x    <= ox;
      req_own_y    <= oy;
      do @(posedge clock); while (busy);
      heading_due.push_back(predict_heading(tx, ty, ox, oy));
   endtask

   // random own point, target placed at the given offset (wraps)
   task automatic send_offset(coord_type dx, coord_type dy);
      coord_type ox, oy;
      ox = coord_type'($urandom);
      oy = coord_type'($urandom);
      send_query(ox + dx, oy + dy, ox, oy);
   endtask

   // offset whose magnitude needs 0..13 normalising shifts, either sign
   function automatic coord_type random_offset();
      int unsigned span, mag;
      span = 32'h700 << $urandom_range(0, 14);
      mag  = $urandom_range(span - 1, 0);
      if ($urandom_range(9) == 0)
         mag = 0;
      return $urandom_range(1) ? coord_type'(-mag) : coord_type'(mag);
   endfunction

   task automatic wait_drained();
      start <= 1'b0;
      do @(posedge clock); while (heading_due.size() != 0);
   endtask

   // zero, rounding and normalising boundaries, wrap-around, extremes
   task automatic test_directed_cases();
      send_query(24'h000000, 24'h000000, 24'h000000, 24'h000000);
      send_query(24'h123456, 24'h654321, 24'h123456, 24'h654321);
      send_query(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
      send_query(24'hFFFFFF, 24'hFFFFFF, 24'h000000, 24'h000000);
      send_query(24'h000000, 24'h000000, 24'hFFFFFF, 24'hFFFFFF);
      // most negative difference on each axis and both
      send_query(24'h800000, 24'h000000, 24'h000000, 24'h000000);
      send_query(24'h000000, 24'h800000, 24'h000000, 24'h000000);
      send_query(24'h800000, 24'h800000, 24'h000000, 24'h000000);
      send_query(24'h7FFFFF, 24'h000000, 24'h000000, 24'h000000);
      send_query(24'h000000, 24'h7FFFFF, 24'h000000, 24'h000000);
      // rounding bit just below and at the threshold
      send_query(24'h00007F, 24'h000000, 24'h000000, 24'h000000);
      send_query(24'h000080, 24'h000000, 24'h000000, 24'h000000);
      send_query(24'h000000, 24'h000080, 24'h000000, 24'h000000);
      // normalising bound
      send_query(24'h0006FF, 24'h0006FF, 24'h000000, 24'h000000);
      send_query(24'h000700, 24'h000000, 24'h000000, 24'h000000);
      send_query(24'h000000, 24'h000700, 24'h000000, 24'h000000);
      // wrap across zero, all four quadrants
      send_query(24'h000010, 24'h000300, 24'hFFFFF0, 24'h000000);
      send_query(24'h000000, 24'h000300, 24'h000400, 24'h000000);
      send_query(24'h000000, 24'h000000, 24'h000400, 24'h000300);
      send_query(24'h000400, 24'h000000, 24'h000000, 24'h000300);
      send_query(24'h000500, 24'h000500, 24'h000000, 24'h000000);
      send_query(24'hAAAAAA, 24'h555555, 24'h555555, 24'hAAAAAA);
      wait_drained();
   endtask

   // small offsets, at most one normalising shift: walks the whole table
   task automatic test_short_range();
      repeat (150)
         send_offset(coord_type'($urandom_range(12'hDFF, 0) - 12'h6FF),
                     coord_type'($urandom_range(12'hDFF, 0) - 12'h6FF));
      wait_drained();
   endtask

   // arbitrary points over the whole coordinate range
   task automatic test_full_range();
      repeat (150)
         send_query(coord_type'($urandom), coord_type'($urandom),
                    coord_type'($urandom), coord_type'($urandom));
      wait_drained();
   endtask

   // every normalising depth, sender never pauses
   task automatic test_back_to_back();
      gaps_on = 1'b0;
      repeat (150)
         send_offset(random_offset(), random_offset());
      gaps_on = 1'b1;
      wait_drained();
   endtask

   // every normalising depth with sender pauses
   task automatic test_mixed_depths();
      repeat (150)
         send_offset(random_offset(), random_offset());
      wait_drained();
   endtask

   // result beats against the oldest outstanding expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (heading_due.size() == 0)
            report_mismatch("unexpected result beat", -1, int'(rsp_direction));
         else if (rsp_direction !== heading_due[0])
            report_mismatch("direction", int'(heading_due.pop_front()), int'(rsp_direction));
         else
            void'(heading_due.pop_front());
      end
   end

   // watchdog on cycles with no beat in either direction
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid)
         quiet_cycles <= 0;
      else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("target_direction_quantizer_tb: done, errors");
         $finish;
      end else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      mismatch_count = 0;
      gaps_on        = 1'b1;
      reset        <= 1'b1;
      start        <= 1'b0;
      req_target_x <= '0;
      req_target_y <= '0;
      req_own_x    <= '0;
      req_own_y    <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_directed_cases();
      test_short_range();
      test_full_range();
      test_back_to_back();
      test_mixed_depths();

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && heading_due.size() == 0)
         $display("target_direction_quantizer_tb: done, clean");
      else
         $display("target_direction_quantizer_tb: done, errors");
      $finish;
   end

endmodule
